>>> design/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncc_pkg: shared definitions for the neuron co-activation counter
// Sizes, command codes, controller states and the memory request bundle.
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int HIDDEN_SIZE = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int RELU_SHIFT  = 5;

  localparam int IDX_W    = $clog2(HIDDEN_SIZE);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 8;
  localparam int RESULT_W = 32;

  // A neuron is active when max(0,v) >> RELU_SHIFT is nonzero, i.e. v >= 2^RELU_SHIFT.
  localparam logic signed [SAMPLE_W-1:0] ACT_THRESH = SAMPLE_W'(1 << RELU_SHIFT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIDDEN_SIZE - 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

endpackage
`default_nettype wire

>>> design/ncc_counter_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncc_counter_ram: pair counter storage
// One write port and one registered read port; a read of the entry being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module ncc_counter_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/ncc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncc_ctrl: load tracking and counter update sequencer
// Collects the active flags of a position, sweeps all neuron pairs with a
// read-increment-write pipeline, and clears the counter memory after reset.
// ----------------------------------------------------------------------------
module ncc_ctrl (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic                                   command,
  input  wire logic signed [ncc_pkg::SAMPLE_W-1:0]    sample_value,
  input  wire logic                                   is_last,
  input  wire logic        [ncc_pkg::INDEX_W-1:0]     row_index,
  input  wire logic        [ncc_pkg::INDEX_W-1:0]     col_index,
  input  wire logic        [ncc_pkg::COUNT_WIDTH-1:0] rd_data,
  output logic                                        busy,
  output ncc_pkg::mem_req_t                           mem_req
);

  import ncc_pkg::*;

  state_t state, state_next;

  logic [HIDDEN_SIZE-1:0] flags;
  logic [HIDDEN_SIZE-1:0] flags_upd;
  logic [HIDDEN_SIZE-1:0] row_flags;
  logic [HIDDEN_SIZE-1:0] col_flags;

  logic [IDX_W-1:0]  ld_neuron;
  logic              ld_half;
  logic              ld_full;
  logic [IDX_W-1:0]  sw_row;
  logic [IDX_W-1:0]  sw_col;
  logic [ADDR_W-1:0] clr_addr;

  logic              wb_act;
  logic [ADDR_W-1:0] wb_addr;

  logic accept;
  logic load_acc;
  logic last_acc;
  logic act_in;
  logic sweep_end;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_acc  = accept && (command == CMD_LOAD);
  assign last_acc  = load_acc && is_last;
  assign act_in    = (sample_value >= ACT_THRESH);
  assign sweep_end = (sw_row == LAST_IDX) && (sw_col == LAST_IDX);

  always_comb begin
    for (int k = 0; k < HIDDEN_SIZE; k++) begin
      flags_upd[k] = flags[k] |
        (load_acc && !ld_full && act_in && (ld_neuron == IDX_W'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mem_req.we    = wb_act;
    mem_req.waddr = wb_addr;
    mem_req.wdata = (rd_data == '1) ? rd_data : rd_data + 1'b1;
    mem_req.raddr = {IDX_W'(row_index), IDX_W'(col_index)};
    unique case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
        mem_req.wdata = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (last_acc) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        mem_req.raddr = {sw_row, sw_col};
        if (sweep_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Flags of the position being loaded; cleared once handed to the sweep.
  always_ff @(posedge clk) begin
    if (rst || last_acc) begin
      flags <= '0;
    end else if (load_acc) begin
      flags <= flags_upd;
    end
  end

  // Rotating copies: bit 0 always holds the flag of the current row or column.
  always_ff @(posedge clk) begin
    if (last_acc) begin
      row_flags <= flags_upd;
      col_flags <= flags_upd;
    end else if (state == ST_SWEEP) begin
      col_flags <= {col_flags[0], col_flags[HIDDEN_SIZE-1:1]};
      if (sw_col == LAST_IDX) begin
        row_flags <= {row_flags[0], row_flags[HIDDEN_SIZE-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || last_acc) begin
      ld_neuron <= '0;
      ld_half   <= 1'b0;
      ld_full   <= 1'b0;
    end else if (load_acc && !ld_full) begin
      if (ld_neuron == LAST_IDX) begin
        ld_neuron <= '0;
        if (ld_half) begin
          ld_full <= 1'b1;
        end
        ld_half <= 1'b1;
      end else begin
        ld_neuron <= ld_neuron + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || last_acc) begin
      sw_row <= '0;
      sw_col <= '0;
    end else if (state == ST_SWEEP) begin
      if (sw_col == LAST_IDX) begin
        sw_col <= '0;
        sw_row <= sw_row + 1'b1;
      end else begin
        sw_col <= sw_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Write-back stage: the counter read this cycle is incremented next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_act <= 1'b0;
    end else begin
      wb_act <= (state == ST_SWEEP) && row_flags[0] && col_flags[0];
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= {sw_row, sw_col};
  end

endmodule
`default_nettype wire

>>> design/neuron_coactivation_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// Reads: a read command returns its pair count in the cycle after the transfer.
// Throughput: loads and reads are taken one per cycle while busy is low; a load
// marked last starts a sweep over all HIDDEN_SIZE^2 counters through the single
// read-increment-write path of the counter memory, and busy is high meanwhile.
// Reset: synchronous; after it, a clearing pass zeroes the counter memory one
// entry per cycle with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
// neuron_coactivation_counter: counts co-activation of hidden neuron pairs
// Loads accumulator vectors, flags neurons whose clipped ReLU is nonzero, and
// increments a saturating counter for every pair of active neurons.
// ----------------------------------------------------------------------------
module neuron_coactivation_counter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                command,
  input  wire logic signed [ncc_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic                                is_last,
  input  wire logic        [ncc_pkg::INDEX_W-1:0]  row_index,
  input  wire logic        [ncc_pkg::INDEX_W-1:0]  col_index,
  output logic                                     valid,
  output logic             [ncc_pkg::RESULT_W-1:0] pair_count
);

  import ncc_pkg::*;

  mem_req_t               mem_req;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_inrange;
  logic                   in_range;
  logic                   read_acc;

  // A read transfer addresses the counter memory directly; the registered
  // memory output is then shown for one cycle with the valid strobe.
  assign read_acc = start && !busy && (command == CMD_READ);
  assign in_range = (int'(row_index) < HIDDEN_SIZE) && (int'(col_index) < HIDDEN_SIZE);

  ncc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .sample_value (sample_value),
    .is_last      (is_last),
    .row_index    (row_index),
    .col_index    (col_index),
    .rd_data      (rd_data),
    .busy         (busy),
    .mem_req      (mem_req)
  );

  // The memory forwards a same-cycle write, so a read right after a sweep's
  // final write-back still sees the updated counter.
  ncc_counter_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= read_acc;
    end
  end

  always_ff @(posedge clk) begin
    rd_inrange <= in_range;
  end

  // Counters wider than the result port are clamped to the port's maximum.
  always_comb begin
    if (!rd_inrange) begin
      pair_count = '0;
    end else if ((COUNT_WIDTH > RESULT_W) &&
                 (rd_data > COUNT_WIDTH'({RESULT_W{1'b1}}))) begin
      pair_count = '1;
    end else begin
      pair_count = RESULT_W'(rd_data);
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_neuron_coactivation_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neuron_coactivation_counter: self-checking bench for the co-activation counter
// Streams load and read commands through the start/busy handshake and keeps a
// cycle-accurate-free shadow of the neuron flags and pair tallies. Every read
// result is checked against the tally that the shadow holds when the read is taken.
// ----------------------------------------------------------------------------
module tb_neuron_coactivation_counter;
  import ncc_pkg::*;

  // The run normally spans the clearing pass after reset, nine full sweeps of
  // the pair memory, and the command stream with its gaps.
  localparam int CYCLE_LIMIT = 4_000_000;

  // One command as the bench queues it. Fields that a command ignores are still
  // filled with random values so that the block is seen to ignore them.
  typedef struct {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
    logic [INDEX_W-1:0]         row;
    logic [INDEX_W-1:0]         col;
    bit                         drain;  // hold this command until all reads have returned
  } ncc_op_t;

  // Block ports. Every input is known from time zero.
  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       start        = 1'b0;
  logic                       command      = CMD_LOAD;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic                       is_last      = 1'b0;
  logic [INDEX_W-1:0]         row_index    = '0;
  logic [INDEX_W-1:0]         col_index    = '0;
  logic                       busy;
  logic                       valid;
  logic [RESULT_W-1:0]        pair_count;

  // Shadow of the block state, updated once per accepted transfer.
  bit [HIDDEN_SIZE-1:0]  neuron_hot;
  int                    fill_count;
  bit [COUNT_WIDTH-1:0]  pair_tally [HIDDEN_SIZE][HIDDEN_SIZE];

  // Commands waiting to be driven, and pair counts still owed by the block.
  ncc_op_t             pending_ops[$];
  logic [RESULT_W-1:0] expected_counts[$];

  ncc_op_t cur_op;
  int      total_ops;
  int      accepted_ops;
  int      gap_left;
  bit      steady;
  int      mismatch_count;
  int      cycle_count;

  // Generator bookkeeping: which neurons the position being built has lit up,
  // so that many reads land on pairs with nonzero tallies.
  int      gen_fill;
  int      recent_hot[$];

  neuron_coactivation_counter DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .sample_value (sample_value),
    .is_last      (is_last),
    .row_index    (row_index),
    .col_index    (col_index),
    .valid        (valid),
    .pair_count   (pair_count)
  );

  always #5 clk = ~clk;

  // Applies one accepted command to the shadow state. A read queues the pair
  // count it must return; a load sets a neuron flag and, when it closes the
  // position, bumps every active pair and clears the flags.
  function automatic void account_op(ncc_op_t op);
    bit [COUNT_WIDTH-1:0] tally;
    if (op.cmd == CMD_READ) begin
      tally = '0;
      if (int'(op.row) < HIDDEN_SIZE && int'(op.col) < HIDDEN_SIZE) begin
        tally = pair_tally[op.row][op.col];
      end
      // A counter wider than the result port reports its saturated value.
      if (64'(tally) > 64'hFFFF_FFFF) begin
        expected_counts.push_back('1);
      end else begin
        expected_counts.push_back(RESULT_W'(tally));
      end
    end else begin
      // Values past the second perspective are dropped, but their last flag
      // still closes the position.
      if (fill_count < 2 * HIDDEN_SIZE) begin
        if (op.value >= ACT_THRESH) begin
          neuron_hot[fill_count % HIDDEN_SIZE] = 1'b1;
        end
        fill_count++;
      end
      if (op.last) begin
        for (int i = 0; i < HIDDEN_SIZE; i++) begin
          if (neuron_hot[i]) begin
            for (int j = 0; j < HIDDEN_SIZE; j++) begin
              if (neuron_hot[j] && pair_tally[i][j] != '1) begin
                pair_tally[i][j]++;
              end
            end
          end
        end
        neuron_hot = '0;
        fill_count = 0;
      end
    end
  endfunction

  function automatic void push_op(logic cmd, logic signed [SAMPLE_W-1:0] value, logic last,
                                  logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col,
                                  bit drain);
    ncc_op_t op;
    op.cmd   = cmd;
    op.value = value;
    op.last  = last;
    op.row   = row;
    op.col   = col;
    op.drain = drain;
    pending_ops.push_back(op);
  endfunction

  // Sample values cluster around the activity threshold and the extremes, with
  // some fully random words so that every bit toggles. pct is the chance that a
  // value not drawn fully at random makes its neuron active.
  function automatic logic signed [SAMPLE_W-1:0] pick_value(int pct);
    if ($urandom_range(0, 99) < 10) begin
      return SAMPLE_W'($urandom);
    end
    if ($urandom_range(0, 99) < pct) begin
      case ($urandom_range(0, 3))
        0:       return ACT_THRESH;
        1:       return SAMPLE_W'($urandom_range(32, 40));
        2:       return SAMPLE_W'(32767);
        default: return SAMPLE_W'($urandom_range(32, 32767));
      endcase
    end
    case ($urandom_range(0, 5))
      0:       return SAMPLE_W'(31);
      1:       return '0;
      2:       return SAMPLE_W'(-1);
      3:       return SAMPLE_W'(-32768);
      4:       return SAMPLE_W'($urandom_range(0, 31));
      default: return SAMPLE_W'(32'h8000 | $urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && recent_hot.size() > 0) begin
      return INDEX_W'(recent_hot[$urandom_range(0, recent_hot.size() - 1)]);
    end
    if (r == 5) begin
      return '0;
    end
    if (r == 6) begin
      return '1;
    end
    return INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
  endfunction

  function automatic void push_load(int pct, logic last);
    logic signed [SAMPLE_W-1:0] value;
    value = pick_value(pct);
    if (gen_fill < 2 * HIDDEN_SIZE && value >= ACT_THRESH) begin
      recent_hot.push_back(gen_fill % HIDDEN_SIZE);
    end
    gen_fill++;
    push_op(CMD_LOAD, value, last, INDEX_W'($urandom), INDEX_W'($urandom), 1'b0);
  endfunction

  // Reads carry random load fields, which the block must ignore.
  function automatic void push_read(logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col,
                                    bit drain);
    push_op(CMD_READ, SAMPLE_W'($urandom), 1'($urandom), row, col, drain);
  endfunction

  // Idle time between transfers: mostly none or short, now and then long.
  // While steady is set the stream runs back to back.
  function automatic int draw_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 60);
  endfunction

  // Driver. A transfer happens at an edge where start is high and busy is low.
  // The shadow model is updated at that edge, so a read's expectation is queued
  // before its result can appear. A command marked for draining is only launched
  // from an idle cycle with no read outstanding; a result that is being taken at
  // this very edge counts as returned whichever block runs first.
  always @(posedge clk) begin : driver
    bit launch;
    bit free;
    bit drained;
    launch = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        account_op(cur_op);
        accepted_ops++;
        if (accepted_ops % 64 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
      end
      free    = !start || !busy;
      drained = !start &&
                (expected_counts.size() == 0 ||
                 (expected_counts.size() == 1 && valid === 1'b1));
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0 && (!pending_ops[0].drain || drained)) begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        cur_op = pending_ops.pop_front();
        command      <= cur_op.cmd;
        sample_value <= cur_op.value;
        is_last      <= cur_op.last;
        row_index    <= cur_op.row;
        col_index    <= cur_op.col;
        start        <= 1'b1;
        gap_left = draw_gap();
      end else if (free) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result is present for exactly one cycle and is taken at the edge
  // that ends it; it must match the oldest pair count still owed.
  always @(posedge clk) begin : monitor
    logic [RESULT_W-1:0] want;
    if (!rst && valid === 1'b1) begin
      if (expected_counts.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pair_count, expected none, actual %0d", $time, pair_count);
      end else begin
        want = expected_counts.pop_front();
        if (pair_count !== want) begin
          mismatch_count++;
          $display("%0t: pair_count expected %0d, actual %0d", $time, want, pair_count);
        end
      end
    end
  end

  // Watchdog for a block that hangs or never answers a read.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int len;
    int pct;
    int burst;

    // Directed part. Reads straight after the clearing pass must see zero,
    // including at both index extremes, and must ignore their load fields.
    push_op(CMD_READ, SAMPLE_W'(32767), 1'b1, '0, '0, 1'b0);
    push_op(CMD_READ, SAMPLE_W'(-32768), 1'b0, '1, '1, 1'b0);

    // A short position that walks the threshold and the extremes of the value
    // range: neurons 0, 3 and 6 end up active, the rest stay quiet.
    push_op(CMD_LOAD, SAMPLE_W'(32), 1'b0, '1, '0, 1'b0);
    push_op(CMD_LOAD, SAMPLE_W'(31), 1'b0, '0, '1, 1'b0);
    push_op(CMD_LOAD, SAMPLE_W'(-32768), 1'b0, '1, '1, 1'b0);
    push_op(CMD_LOAD, SAMPLE_W'(32767), 1'b0, '0, '0, 1'b0);
    push_op(CMD_LOAD, '0, 1'b0, '1, '0, 1'b0);
    push_op(CMD_LOAD, SAMPLE_W'(-1), 1'b0, '0, '1, 1'b0);
    push_op(CMD_LOAD, SAMPLE_W'(33), 1'b1, '1, '1, 1'b0);

    // Active pairs, the diagonal, and pairs with an inactive or unloaded neuron.
    push_read(INDEX_W'(0), INDEX_W'(0), 1'b1);
    push_read(INDEX_W'(0), INDEX_W'(3), 1'b0);
    push_read(INDEX_W'(3), INDEX_W'(6), 1'b0);
    push_read(INDEX_W'(6), INDEX_W'(6), 1'b0);
    push_read(INDEX_W'(1), INDEX_W'(1), 1'b0);
    push_read(INDEX_W'(0), INDEX_W'(1), 1'b0);
    push_read(INDEX_W'(255), INDEX_W'(3), 1'b0);

    // A position made of a single value that is also the last one.
    push_op(CMD_LOAD, SAMPLE_W'(100), 1'b1, '1, '1, 1'b0);
    push_read(INDEX_W'(0), INDEX_W'(0), 1'b1);
    push_read(INDEX_W'(3), INDEX_W'(3), 1'b0);
    push_read(INDEX_W'(0), INDEX_W'(6), 1'b0);

    // Random part: well-formed positions of varied length and activity, with
    // stray reads mixed into the loads and a burst of reads after each one.
    // Lengths cover a full two-perspective position, one that runs past the end,
    // one inside the second perspective, one within the first, and short ones.
    for (int p = 0; p < 7; p++) begin
      pct = $urandom_range(10, 90);
      case (p)
        0:       len = 2 * HIDDEN_SIZE;
        1:       len = 2 * HIDDEN_SIZE + $urandom_range(1, 8);
        3:       len = $urandom_range(HIDDEN_SIZE + 1, 2 * HIDDEN_SIZE - 12);
        5:       len = 1;
        6:       len = $urandom_range(100, HIDDEN_SIZE);
        default: len = $urandom_range(1, 60);
      endcase
      gen_fill = 0;
      recent_hot.delete();
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          push_read(pick_index(), pick_index(), 1'b0);
        end
        push_load(pct, k == len - 1);
      end
      burst = $urandom_range(25, 40);
      for (int k = 0; k < burst; k++) begin
        push_read(pick_index(), pick_index(), k == 0 || $urandom_range(0, 39) == 0);
      end
    end
    total_ops = pending_ops.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last transfer, then for every read to return and any sweep
    // to finish, then for any stray results.
    do @(posedge clk); while (accepted_ops != total_ops);
    do @(posedge clk); while (expected_counts.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ncc_pkg.sv
design/ncc_counter_ram.sv
design/ncc_ctrl.sv
design/neuron_coactivation_counter.sv
tb/tb_neuron_coactivation_counter.sv
